@@ sv/heq_pkg.sv @@
// heq_pkg: shared types and constants of the histogram equalizer
// opcodes, register indexes, channel codes, state types and gray divide constants
// no dependencies
package heq_pkg;

    localparam int MAX_BINS_DEF    = 256;
    localparam int COUNT_WIDTH_DEF = 21;

    localparam int PIX_W       = 8;
    localparam int OPCODE_W    = 3;
    localparam int CHAN_W      = 2;
    localparam int CFG_DATA_W  = 9;
    localparam int LUT_W       = 8;

    // gray = floor(sum / 3) as (sum * 683) >> 11, exact for sum below 2048
    localparam int GRAY_SUM_W  = PIX_W + 2;
    localparam int GRAY_PROD_W = 20;
    localparam logic [GRAY_PROD_W-1:0] GRAY_RECIP = GRAY_PROD_W'(683);
    localparam int GRAY_SHIFT  = 11;

    typedef enum logic [OPCODE_W-1:0] {
        OP_CLEAR      = 3'd0,
        OP_ACCUMULATE = 3'd1,
        OP_BUILD_LUT  = 3'd2,
        OP_MAP        = 3'd3,
        OP_READ_BIN   = 3'd4
    } opcode_t;

    typedef enum logic [CHAN_W-1:0] {
        CH_RED   = 2'd0,
        CH_GREEN = 2'd1,
        CH_BLUE  = 2'd2,
        CH_GRAY  = 2'd3
    } chan_sel_t;

    typedef enum logic {
        CFG_CHANNEL_SELECT = 1'b0,
        CFG_BIN_COUNT      = 1'b1
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_BIN,
        ST_RESOLVE,
        ST_BUILD_READ,
        ST_BUILD_SUM,
        ST_BUILD_MUL,
        ST_BUILD_DIV,
        ST_BUILD_WAIT,
        ST_DONE
    } heq_state_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_CHECK,
        DIV_STEP
    } div_state_t;

endpackage

@@ sv/histogram_equalizer_unit.sv @@
// histogram_equalizer_unit: 8-bit histogram equalization engine, top level
// holds the bin count store, the lookup table and the sequencer; uses heq_pkg, heq_divider
//
// One word in, one word out, one item at a time. Accumulate, map and read bin pass through
// prep, bin, resolve and done; clear and unused opcodes skip resolve (gray divide, bin
// multiply, then a read-modify-write of the bin store through its registered read port);
// the sequencer is idle for the next word once the result is loaded. Build lookup walks
// each bin in use through read, sum, multiply, divide and wait states, the 8-step iterative
// divider forming each table entry; a bin whose entry saturates, or any bin while the pixel
// count is zero, skips the divider steps. Clear works on the bin valid flags, so no clearing
// pass is needed after reset. A new word is accepted while the previous result waits on
// m_ready. Configuration must be written only while idle; the block does not enforce it.
module histogram_equalizer_unit
    import heq_pkg::*;
#(
    parameter int MAX_BINS    = MAX_BINS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [OPCODE_W-1:0]    s_opcode,
    input  logic [PIX_W-1:0]       s_red,
    input  logic [PIX_W-1:0]       s_green,
    input  logic [PIX_W-1:0]       s_blue,
    input  logic [PIX_W-1:0]       s_bin_index,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [COUNT_WIDTH-1:0] m_bin_total,
    output logic [LUT_W-1:0]       m_mapped_value,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic                   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int IW     = $clog2(MAX_BINS);
    localparam int BW     = $clog2(MAX_BINS + 1);
    localparam int BP_W   = PIX_W + BW;
    localparam int CUM_W  = COUNT_WIDTH + IW;
    localparam int PROD_W = CUM_W + BW;
    localparam int IDX_CMP_W = PIX_W + 1;
    localparam logic [CFG_DATA_W-1:0] MAX_BINS_CFG = CFG_DATA_W'(MAX_BINS);
    localparam logic [IDX_CMP_W-1:0]  MAX_BINS_IDX = IDX_CMP_W'(MAX_BINS);

    heq_state_t state_reg, state_next;

    // configuration
    logic [CHAN_W-1:0]      channel_sel_reg;
    logic [BW-1:0]          bins_reg;

    // captured word
    logic [OPCODE_W-1:0]    op_reg;
    logic [PIX_W-1:0]       red_reg, green_reg, blue_reg, idx_reg;

    // datapath
    logic [PIX_W-1:0]       v_reg;
    logic [IW-1:0]          k_reg;
    logic                   idx_ok_reg;
    logic [IW-1:0]          i_reg;
    logic [CUM_W-1:0]       cum_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [COUNT_WIDTH-1:0] pixel_total_reg;
    logic [COUNT_WIDTH-1:0] res_total_reg;
    logic [LUT_W-1:0]       res_map_reg;

    // memories
    logic [COUNT_WIDTH-1:0] bin_mem [MAX_BINS];
    logic [LUT_W-1:0]       lut_mem [MAX_BINS];
    logic [MAX_BINS-1:0]    bin_vld_reg;
    logic [COUNT_WIDTH-1:0] bin_rd_reg;
    logic                   bin_vld_rd_reg;
    logic [LUT_W-1:0]       lut_rd_reg;

    // output register
    logic                   m_valid_reg;
    logic [COUNT_WIDTH-1:0] m_bin_total_reg;
    logic [LUT_W-1:0]       m_mapped_value_reg;

    // control strobes
    logic                   bin_we, lut_we, div_start, out_load, last_bin;
    logic                   div_done;
    logic [LUT_W-1:0]       div_q;

    logic [GRAY_SUM_W-1:0]  gray_sum;
    logic [GRAY_PROD_W-1:0] gray_prod;
    logic [PIX_W-1:0]       src_value;
    logic [BP_W-1:0]        bin_prod;
    logic [IW-1:0]          k_calc;
    logic [IW-1:0]          mem_addr;
    logic [COUNT_WIDTH-1:0] count_seen;
    logic [COUNT_WIDTH-1:0] count_inc;

    // source value and bin number
    assign gray_sum  = GRAY_SUM_W'(red_reg) + GRAY_SUM_W'(green_reg) +
                       GRAY_SUM_W'(blue_reg);
    assign gray_prod = GRAY_PROD_W'(gray_sum) * GRAY_RECIP;

    always_comb begin
        case (channel_sel_reg)
            CH_RED:   src_value = red_reg;
            CH_GREEN: src_value = green_reg;
            CH_BLUE:  src_value = blue_reg;
            default:  src_value = gray_prod[GRAY_SHIFT +: PIX_W];
        endcase
    end

    assign bin_prod = BP_W'(v_reg) * BP_W'(bins_reg);
    assign k_calc   = (op_reg == OP_READ_BIN) ? idx_reg[IW-1:0] : bin_prod[PIX_W +: IW];
    assign mem_addr = (state_reg == ST_BUILD_READ) ? i_reg : k_calc;

    assign count_seen = bin_vld_rd_reg ? bin_rd_reg : '0;
    assign count_inc  = (count_seen == '1) ? count_seen : count_seen + COUNT_WIDTH'(1);
    assign last_bin   = (BW'(i_reg) == bins_reg - BW'(1));

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        bin_we     = 1'b0;
        lut_we     = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: state_next = ST_BIN;
            ST_BIN: begin
                case (op_reg)
                    OP_ACCUMULATE, OP_MAP, OP_READ_BIN: state_next = ST_RESOLVE;
                    OP_BUILD_LUT:                       state_next = ST_BUILD_READ;
                    default:                            state_next = ST_DONE;
                endcase
            end
            ST_RESOLVE: begin
                bin_we     = (op_reg == OP_ACCUMULATE);
                state_next = ST_DONE;
            end
            ST_BUILD_READ: state_next = ST_BUILD_SUM;
            ST_BUILD_SUM:  state_next = ST_BUILD_MUL;
            ST_BUILD_MUL:  state_next = ST_BUILD_DIV;
            ST_BUILD_DIV: begin
                div_start  = 1'b1;
                state_next = ST_BUILD_WAIT;
            end
            ST_BUILD_WAIT: begin
                if (div_done) begin
                    lut_we     = 1'b1;
                    state_next = last_bin ? ST_DONE : ST_BUILD_READ;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // control state with reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            channel_sel_reg <= CH_GRAY;
            bins_reg        <= BW'(MAX_BINS);
            pixel_total_reg <= '0;
            bin_vld_reg     <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_CHANNEL_SELECT: channel_sel_reg <= cfg_data[CHAN_W-1:0];
                    CFG_BIN_COUNT: begin
                        // zero acts as one bin, too many acts as the full store
                        if (cfg_data == '0) begin
                            bins_reg <= BW'(1);
                        end else if (cfg_data > MAX_BINS_CFG) begin
                            bins_reg <= BW'(MAX_BINS);
                        end else begin
                            bins_reg <= BW'(cfg_data);
                        end
                    end
                    default: bins_reg <= bins_reg;
                endcase
            end
            if (state_reg == ST_BIN && op_reg == OP_CLEAR) begin
                bin_vld_reg     <= '0;
                pixel_total_reg <= '0;
            end
            if (bin_we) begin
                bin_vld_reg[k_reg] <= 1'b1;
                if (pixel_total_reg != '1) begin
                    pixel_total_reg <= pixel_total_reg + COUNT_WIDTH'(1);
                end
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg        <= s_opcode;
            red_reg       <= s_red;
            green_reg     <= s_green;
            blue_reg      <= s_blue;
            idx_reg       <= s_bin_index;
            res_total_reg <= '0;
            res_map_reg   <= '0;
        end
        case (state_reg)
            ST_PREP: begin
                v_reg <= (op_reg == OP_MAP) ? red_reg : src_value;
            end
            ST_BIN: begin
                k_reg      <= k_calc;
                idx_ok_reg <= (IDX_CMP_W'(idx_reg) < MAX_BINS_IDX);
                i_reg      <= '0;
                cum_reg    <= '0;
            end
            ST_RESOLVE: begin
                if (op_reg == OP_READ_BIN) begin
                    res_total_reg <= idx_ok_reg ? count_seen : '0;
                end
                if (op_reg == OP_MAP) begin
                    res_map_reg <= lut_rd_reg;
                end
            end
            ST_BUILD_SUM: begin
                cum_reg <= cum_reg + CUM_W'(count_seen);
            end
            ST_BUILD_MUL: begin
                prod_reg <= PROD_W'(cum_reg) * PROD_W'(bins_reg);
            end
            ST_BUILD_WAIT: begin
                if (div_done && !last_bin) begin
                    i_reg <= i_reg + IW'(1);
                end
            end
            default: begin
                v_reg <= v_reg;
            end
        endcase
        if (out_load) begin
            m_bin_total_reg    <= res_total_reg;
            m_mapped_value_reg <= res_map_reg;
        end
    end

    // bin store and lookup table, registered read
    always_ff @(posedge aclk) begin
        bin_rd_reg     <= bin_mem[mem_addr];
        bin_vld_rd_reg <= bin_vld_reg[mem_addr];
        if (bin_we) begin
            bin_mem[k_reg] <= count_inc;
        end
    end

    always_ff @(posedge aclk) begin
        lut_rd_reg <= lut_mem[k_calc];
        if (lut_we) begin
            lut_mem[i_reg] <= div_q;
        end
    end

    heq_divider #(
        .NUM_W (PROD_W),
        .DEN_W (COUNT_WIDTH)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .numer    (prod_reg),
        .denom    (pixel_total_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign m_valid        = m_valid_reg;
    assign m_bin_total    = m_bin_total_reg;
    assign m_mapped_value = m_mapped_value_reg;

    a_accept_drops_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted twice in a row");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_DONE))
        else $error("result word raised outside the done state");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BIN && op_reg == OP_CLEAR) |=>
        (bin_vld_reg == '0 && pixel_total_reg == '0))
        else $error("clear left bins or pixel count behind");

    a_build_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BUILD_READ) |-> (BW'(i_reg) < bins_reg))
        else $error("lookup build walked past the bins in use");

endmodule

@@ sv/heq_divider.sv @@
// heq_divider: iterative restoring divider, one quotient bit per cycle
// quotient saturates at all ones, a zero divisor gives zero; uses heq_pkg
module heq_divider
    import heq_pkg::*;
#(
    parameter int NUM_W = 38,
    parameter int DEN_W = 21
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output logic             done,
    output logic [LUT_W-1:0] quotient
);

    localparam int CW     = (NUM_W > DEN_W + LUT_W) ? NUM_W : DEN_W + LUT_W;
    localparam int STEP_W = $clog2(LUT_W);

    div_state_t          state_reg, state_next;
    logic [CW-1:0]       rem_reg;
    logic [CW-1:0]       dsh_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [LUT_W-1:0]    q_reg;
    logic                done_reg;
    logic                ge;

    assign ge = (rem_reg >= dsh_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DIV_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= ((state_reg == DIV_CHECK) && (dsh_reg == '0 || ge)) ||
                         ((state_reg == DIV_STEP) && (step_reg == '0));
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            DIV_IDLE: begin
                if (start) begin
                    state_next = DIV_CHECK;
                end
            end
            DIV_CHECK: begin
                if (dsh_reg == '0 || ge) begin
                    state_next = DIV_IDLE;
                end else begin
                    state_next = DIV_STEP;
                end
            end
            DIV_STEP: begin
                if (step_reg == '0) begin
                    state_next = DIV_IDLE;
                end
            end
            default: state_next = DIV_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            DIV_IDLE: begin
                if (start) begin
                    rem_reg <= CW'(numer);
                    dsh_reg <= CW'(denom) << LUT_W;
                end
            end
            DIV_CHECK: begin
                // quotient at or above 256 saturates, zero divisor gives zero
                if (dsh_reg == '0) begin
                    q_reg <= '0;
                end else if (ge) begin
                    q_reg <= '1;
                end else begin
                    q_reg    <= '0;
                    dsh_reg  <= dsh_reg >> 1;
                    step_reg <= STEP_W'(LUT_W - 1);
                end
            end
            DIV_STEP: begin
                if (ge) begin
                    rem_reg <= rem_reg - dsh_reg;
                end
                q_reg    <= {q_reg[LUT_W-2:0], ge};
                dsh_reg  <= dsh_reg >> 1;
                step_reg <= step_reg - STEP_W'(1);
            end
            default: begin
                q_reg <= q_reg;
            end
        endcase
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

@@ test/histogram_equalizer_unit_tb.sv @@
// histogram_equalizer_unit_tb: self-checking bench for the histogram equalizer top level
// drives opcode/pixel words and register writes, predicts every result word in-line
// depends on heq_pkg and histogram_equalizer_unit
module histogram_equalizer_unit_tb;
    import heq_pkg::*;

    localparam int LIMIT_CYCLES = 1_500_000;
    localparam int TAIL_CYCLES  = 40;
    localparam int BLOCK_ITEMS  = 60;
    localparam int PROBE_N      = 32;

    localparam logic [OPCODE_W-1:0] OP_UNUSED_LO = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_UNUSED_HI = 3'd7;
    localparam logic [COUNT_WIDTH_DEF-1:0] COUNT_TOP = {COUNT_WIDTH_DEF{1'b1}};

    typedef struct packed {
        logic [COUNT_WIDTH_DEF-1:0] bin_total;
        logic [LUT_W-1:0]           mapped_value;
    } heq_result_t;

    typedef enum logic {RK_WORD, RK_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t                  kind;
        logic [OPCODE_W-1:0]        op;
        logic [PIX_W-1:0]           red;
        logic [PIX_W-1:0]           green;
        logic [PIX_W-1:0]           blue;
        logic [PIX_W-1:0]           index;
        cfg_index_t                 cfg_sel;
        logic [CFG_DATA_W-1:0]      cfg_val;
        logic                       fixed;
        logic [COUNT_WIDTH_DEF-1:0] want_total;
        logic [LUT_W-1:0]           want_map;
    } probe_row_t;

    // kind, op, red, green, blue, index, register, value, fixed, total, mapped
    localparam probe_row_t PROBE_ROWS [PROBE_N] = '{
        '{RK_WORD, OP_READ_BIN,     0,   0,   0,   0, CFG_CHANNEL_SELECT, 0, 1, 0, 0},
        '{RK_WORD, OP_READ_BIN,     0,   0,   0, 255, CFG_CHANNEL_SELECT, 0, 1, 0, 0},
        '{RK_WORD, OP_UNUSED_HI,  255, 255, 255, 255, CFG_CHANNEL_SELECT, 0, 1, 0, 0},
        '{RK_WORD, OP_UNUSED_LO,    0,   0,   0,   0, CFG_CHANNEL_SELECT, 0, 1, 0, 0},
        // table built from an empty histogram is all zero
        '{RK_WORD, OP_BUILD_LUT,    0,   0,   0,   0, CFG_CHANNEL_SELECT, 0, 1, 0, 0},
        '{RK_WORD, OP_MAP,        255,   0,   0,   0, CFG_CHANNEL_SELECT, 0, 1, 0, 0},
        '{RK_WORD, OP_MAP,          0,   0,   0,   0, CFG_CHANNEL_SELECT, 0, 1, 0, 0},
        '{RK_WORD, OP_ACCUMULATE, 255, 255, 255,   0, CFG_CHANNEL_SELECT, 0, 1, 0, 0},
        '{RK_WORD, OP_ACCUMULATE,   0,   0,   0,   0, CFG_CHANNEL_SELECT, 0, 1, 0, 0},
        '{RK_WORD, OP_ACCUMULATE,   1,   2,   3,   0, CFG_CHANNEL_SELECT, 0, 1, 0, 0},
        '{RK_WORD, OP_ACCUMULATE, 254, 255, 255,   0, CFG_CHANNEL_SELECT, 0, 1, 0, 0},
        '{RK_WORD, OP_READ_BIN,     0,   0,   0, 255, CFG_CHANNEL_SELECT, 0, 1, 1, 0},
        '{RK_WORD, OP_READ_BIN,     0,   0,   0,   0, CFG_CHANNEL_SELECT, 0, 1, 1, 0},
        '{RK_WORD, OP_BUILD_LUT,    0,   0,   0,   0, CFG_CHANNEL_SELECT, 0, 1, 0, 0},
        // top entry clamps at 255
        '{RK_WORD, OP_MAP,        255,   0,   0,   0, CFG_CHANNEL_SELECT, 0, 1, 0, 255},
        '{RK_WORD, OP_MAP,          0,   0,   0,   0, CFG_CHANNEL_SELECT, 0, 0, 0, 0},
        '{RK_WORD, OP_MAP,        128,   0,   0,   0, CFG_CHANNEL_SELECT, 0, 0, 0, 0},
        '{RK_CFG,  OP_CLEAR,        0,   0,   0,   0, CFG_CHANNEL_SELECT, CH_RED, 0, 0, 0},
        // zero bins behaves as a single bin
        '{RK_CFG,  OP_CLEAR,        0,   0,   0,   0, CFG_BIN_COUNT, 0, 0, 0, 0},
        '{RK_WORD, OP_ACCUMULATE, 200,   7,   9,   0, CFG_CHANNEL_SELECT, 0, 1, 0, 0},
        '{RK_WORD, OP_BUILD_LUT,    0,   0,   0,   0, CFG_CHANNEL_SELECT, 0, 1, 0, 0},
        '{RK_WORD, OP_MAP,        170,   0,   0,   0, CFG_CHANNEL_SELECT, 0, 0, 0, 0},
        // bin above the range in use keeps its old count
        '{RK_WORD, OP_READ_BIN,     0,   0,   0, 254, CFG_CHANNEL_SELECT, 0, 0, 0, 0},
        '{RK_CFG,  OP_CLEAR,        0,   0,   0,   0, CFG_BIN_COUNT, 511, 0, 0, 0},
        '{RK_CFG,  OP_CLEAR,        0,   0,   0,   0, CFG_CHANNEL_SELECT, CH_GREEN, 0, 0, 0},
        '{RK_WORD, OP_ACCUMULATE,   0, 128,   0,   0, CFG_CHANNEL_SELECT, 0, 1, 0, 0},
        '{RK_WORD, OP_MAP,        128,   0,   0,   0, CFG_CHANNEL_SELECT, 0, 0, 0, 0},
        '{RK_WORD, OP_CLEAR,        0,   0,   0,   0, CFG_CHANNEL_SELECT, 0, 1, 0, 0},
        '{RK_WORD, OP_READ_BIN,     0,   0,   0, 128, CFG_CHANNEL_SELECT, 0, 1, 0, 0},
        '{RK_CFG,  OP_CLEAR,        0,   0,   0,   0, CFG_CHANNEL_SELECT, CH_BLUE, 0, 0, 0},
        '{RK_WORD, OP_ACCUMULATE,   0,   0, 255,   0, CFG_CHANNEL_SELECT, 0, 1, 0, 0},
        '{RK_WORD, OP_READ_BIN,     0,   0,   0, 255, CFG_CHANNEL_SELECT, 0, 0, 0, 0}
    };

    logic                       aclk;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic [OPCODE_W-1:0]        s_opcode = '0;
    logic [PIX_W-1:0]           s_red = '0;
    logic [PIX_W-1:0]           s_green = '0;
    logic [PIX_W-1:0]           s_blue = '0;
    logic [PIX_W-1:0]           s_bin_index = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [COUNT_WIDTH_DEF-1:0] m_bin_total;
    logic [LUT_W-1:0]           m_mapped_value;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic                       cfg_index = 1'b0;
    logic [CFG_DATA_W-1:0]      cfg_data = '0;

    // shadow of the block state
    chan_sel_t                  src_chan = CH_GRAY;
    logic [CFG_DATA_W-1:0]      bins_reg = 9'd256;
    logic [COUNT_WIDTH_DEF-1:0] bin_tally [MAX_BINS_DEF];
    logic [COUNT_WIDTH_DEF-1:0] pixel_tally = '0;
    logic [LUT_W-1:0]           equal_lut [MAX_BINS_DEF];
    bit                         lut_written [MAX_BINS_DEF];

    heq_result_t outcomes_due[$];
    heq_result_t head_want;
    int          fail_count = 0;
    int unsigned cycle_count = 0;
    int          words_done = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    histogram_equalizer_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_red          (s_red),
        .s_green        (s_green),
        .s_blue         (s_blue),
        .s_bin_index    (s_bin_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_bin_total    (m_bin_total),
        .m_mapped_value (m_mapped_value),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic int unsigned bins_used();
        if (bins_reg == 0) return 1;
        if (bins_reg > MAX_BINS_DEF) return MAX_BINS_DEF;
        return 32'(bins_reg);
    endfunction

    function automatic int unsigned bin_of(int unsigned level, int unsigned span);
        return (level * span) / 256;
    endfunction

    function automatic logic [PIX_W-1:0] near_value(int center, int spread);
        int v;
        v = center - spread + int'($urandom_range(2 * spread, 0));
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return PIX_W'(v);
    endfunction

    // result word for one accepted input word, updating the shadow state
    function automatic heq_result_t equalizer_outcome(logic [OPCODE_W-1:0] op,
                                                      logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                                                      logic [PIX_W-1:0] bl,
                                                      logic [PIX_W-1:0] idx);
        heq_result_t     res;
        int unsigned     span;
        int unsigned     level;
        int unsigned     slot;
        longint unsigned running;
        longint unsigned entry;
        res = '0;
        span = bins_used();
        case (op)
            OP_CLEAR: begin
                foreach (bin_tally[j]) bin_tally[j] = '0;
                pixel_tally = '0;
            end
            OP_ACCUMULATE: begin
                case (src_chan)
                    CH_RED:   level = 32'(r);
                    CH_GREEN: level = 32'(g);
                    CH_BLUE:  level = 32'(bl);
                    default:  level = (32'(r) + 32'(g) + 32'(bl)) / 3;
                endcase
                slot = bin_of(level, span);
                if (bin_tally[slot] != COUNT_TOP)
                    bin_tally[slot] = bin_tally[slot] + COUNT_WIDTH_DEF'(1);
                if (pixel_tally != COUNT_TOP)
                    pixel_tally = pixel_tally + COUNT_WIDTH_DEF'(1);
            end
            OP_BUILD_LUT: begin
                running = 0;
                for (int k = 0; k < span; k++) begin
                    running += 64'(bin_tally[k]);
                    entry = 0;
                    if (pixel_tally != 0) begin
                        entry = (running * 64'(span)) / 64'(pixel_tally);
                        if (entry > 255) entry = 255;
                    end
                    equal_lut[k] = entry[LUT_W-1:0];
                    lut_written[k] = 1'b1;
                end
            end
            OP_MAP: res.mapped_value = equal_lut[bin_of(32'(r), span)];
            OP_READ_BIN: res.bin_total = bin_tally[idx];
            default: ;
        endcase
        return res;
    endfunction

    task automatic push_word(input logic [OPCODE_W-1:0] op, input logic [PIX_W-1:0] r,
                             input logic [PIX_W-1:0] g, input logic [PIX_W-1:0] bl,
                             input logic [PIX_W-1:0] idx, input logic fixed,
                             input heq_result_t typed);
        heq_result_t         predicted;
        logic [OPCODE_W-1:0] code;
        code = op;
        // a map must land on a table entry some build has written
        if (code == OP_MAP && !lut_written[bin_of(32'(r), bins_used())]) code = OP_READ_BIN;
        cfg_valid <= 1'b0;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_opcode    <= code;
        s_red       <= r;
        s_green     <= g;
        s_blue      <= bl;
        s_bin_index <= idx;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = equalizer_outcome(code, r, g, bl, idx);
        outcomes_due.push_back(fixed ? typed : predicted);
        if (code <= OP_READ_BIN) words_done++;
    endtask

    // hold the sender until every result word is back
    task automatic drain_results();
        s_valid   <= 1'b0;
        cfg_valid <= 1'b0;
        @(posedge aclk);
        while (outcomes_due.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t sel, input logic [CFG_DATA_W-1:0] val);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (sel == CFG_CHANNEL_SELECT) src_chan = chan_sel_t'(val[CHAN_W-1:0]);
        else bins_reg = val;
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (outcomes_due.size() == 0) begin
                $error("result word with nothing awaited: bin_total %0d mapped_value %0d",
                       m_bin_total, m_mapped_value);
                fail_count++;
            end else begin
                head_want = outcomes_due.pop_front();
                if (m_bin_total !== head_want.bin_total) begin
                    $error("bin_total: expected %0d, actual %0d",
                           head_want.bin_total, m_bin_total);
                    fail_count++;
                end
                if (m_mapped_value !== head_want.mapped_value) begin
                    $error("mapped_value: expected %0d, actual %0d",
                           head_want.mapped_value, m_mapped_value);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int span_pick;
        int center;
        int spread;
        int block_start;
        foreach (bin_tally[j]) begin
            bin_tally[j]   = '0;
            equal_lut[j]   = '0;
            lut_written[j] = 1'b0;
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < PROBE_N; i++) begin
            if (PROBE_ROWS[i].kind == RK_CFG) begin
                write_reg(PROBE_ROWS[i].cfg_sel, PROBE_ROWS[i].cfg_val);
            end else begin
                push_word(PROBE_ROWS[i].op, PROBE_ROWS[i].red, PROBE_ROWS[i].green,
                          PROBE_ROWS[i].blue, PROBE_ROWS[i].index, PROBE_ROWS[i].fixed,
                          '{PROBE_ROWS[i].want_total, PROBE_ROWS[i].want_map});
            end
        end

        for (int mode = 0; mode < 4; mode++) begin
            case (mode)
                0: begin
                    send_idle_pct = 0;  recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 78; recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;  recv_stall_pct = 78;
                end
                default: begin
                    send_idle_pct = 30; recv_stall_pct = 30;
                end
            endcase
            for (int blk = 0; blk < 6; blk++) begin
                write_reg(CFG_CHANNEL_SELECT, CFG_DATA_W'((blk + mode) % 4));
                case (blk)
                    0: span_pick = $urandom_range(16, 2);
                    1: span_pick = $urandom_range(1, 0);
                    2: span_pick = $urandom_range(64, 17);
                    3: span_pick = $urandom_range(1, 0) ? 256 : $urandom_range(511, 257);
                    4: span_pick = $urandom_range(8, 1);
                    default: span_pick = $urandom_range(255, 65);
                endcase
                write_reg(CFG_BIN_COUNT, CFG_DATA_W'(span_pick));
                block_start = words_done;
                while (words_done - block_start < BLOCK_ITEMS) begin
                    if ($urandom_range(1) == 0)
                        push_word(OP_CLEAR, PIX_W'($urandom), PIX_W'($urandom),
                                  PIX_W'($urandom), PIX_W'($urandom), 1'b0, '0);
                    center = $urandom_range(255);
                    case ($urandom_range(2))
                        0: spread = 4;
                        1: spread = 24;
                        default: spread = 128;
                    endcase
                    repeat ($urandom_range(40, 1))
                        push_word(OP_ACCUMULATE, near_value(center, spread),
                                  near_value(center, spread), near_value(center, spread),
                                  PIX_W'($urandom), 1'b0, '0);
                    push_word(OP_BUILD_LUT, PIX_W'($urandom), PIX_W'($urandom),
                              PIX_W'($urandom), PIX_W'($urandom), 1'b0, '0);
                    if ($urandom_range(2) == 0) drain_results();
                    repeat ($urandom_range(15, 1))
                        push_word(OP_MAP, PIX_W'($urandom), PIX_W'($urandom),
                                  PIX_W'($urandom), PIX_W'($urandom), 1'b0, '0);
                    repeat ($urandom_range(5, 0))
                        push_word(OP_READ_BIN, PIX_W'($urandom), PIX_W'($urandom),
                                  PIX_W'($urandom), PIX_W'($urandom), 1'b0, '0);
                    // noise: any opcode with random fields
                    if ($urandom_range(99) < 20)
                        repeat ($urandom_range(6, 1))
                            push_word(OPCODE_W'($urandom_range(OP_UNUSED_HI, OP_CLEAR)),
                                      PIX_W'($urandom), PIX_W'($urandom),
                                      PIX_W'($urandom), PIX_W'($urandom), 1'b0, '0);
                end
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

endmodule
